>>> src/dcf_pkg.sv
`timescale 1ns / 1ps

package dcf_pkg;

    localparam int CH_W      = 5;
    localparam int LEVEL_W   = 8;
    localparam int DUR_W     = 16;
    localparam int TICKS_W   = 12;
    localparam int MAX_TICKS = 4095;
    localparam int EMIT_MAX  = 24;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] level;
        logic [DUR_W-1:0]   duration_ms;
    } in_req_t;

    typedef struct packed {
        logic [CH_W-1:0]    channel_out;
        logic [LEVEL_W-1:0] level_out;
        logic               fading;
        logic               last;
    } out_req_t;

    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_LOAD,
        CELL_TICK,
        CELL_CAPTURE,
        CELL_LATCH,
        CELL_DIV,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] level;
        logic [TICKS_W-1:0] divisor;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TDIV,
        ST_CDIV,
        ST_EMIT
    } state_t;

endpackage

>>> src/dmx_channel_crossfade_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_data   (in_req_t)
// m_       out        m_valid / m_ready  m_data   (out_req_t)
//
// A load request sets one channel's target. A start request is accepted, then the duration
// is divided by TICK_MS by multiplying with its reciprocal, then every cell divides
// its level difference by the tick count. A tick request updates all cells when accepted
// (at a tick count of zero they only capture their levels), then shifts min(CHANNELS, 24)
// levels out of the chain, one per accepted result. Reset clears levels, targets and the
// tick count at once. A low m_ready holds the chain and the output where they are.

module dmx_channel_crossfade_top #(
    parameter int CHANNELS = 24,
    parameter int TICK_MS  = 20
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dcf_pkg::in_req_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dcf_pkg::out_req_t m_data
);
    import dcf_pkg::*;

    localparam int EmitN      = (CHANNELS < EMIT_MAX) ? CHANNELS : EMIT_MAX;
    localparam int CntW       = (EmitN > 1) ? $clog2(EmitN) : 1;
    localparam int StepW      = $clog2(LEVEL_W);
    localparam int RecipShift = DUR_W + $clog2(TICK_MS);
    localparam int RecipW     = DUR_W + 2;
    localparam int ProdW      = DUR_W + RecipW;
    localparam logic [ProdW-1:0] Recip =
        ProdW'(((1 << RecipShift) + TICK_MS - 1) / TICK_MS);

    state_t state_reg, state_next;

    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic [DUR_W-1:0]   dvd_reg;
    logic [StepW-1:0]   step_reg;
    logic [CntW-1:0]    emit_cnt_reg;
    logic               fading_reg;

    logic [ProdW-1:0]   prod;
    logic [DUR_W-1:0]   quot;
    logic               cdiv_done;
    logic               emit_last;
    logic               in_fire;
    logic               out_fire;

    cell_ctrl_t                ctrl;
    logic [LEVEL_W-1:0]        chain [CHANNELS+1];

    assign in_fire   = s_valid && s_ready;
    assign out_fire  = m_valid && m_ready;
    assign cdiv_done = step_reg == StepW'(LEVEL_W - 1);
    assign emit_last = emit_cnt_reg == CntW'(EmitN - 1);

    // The reciprocal is rounded up so that the quotient is exact for every duration.
    always_comb begin
        prod = ProdW'(dvd_reg) * Recip;
        quot = DUR_W'(prod >> RecipShift);
        if (quot == '0) begin
            ticks_next = TICKS_W'(1);
        end else if (quot > DUR_W'(MAX_TICKS)) begin
            ticks_next = TICKS_W'(MAX_TICKS);
        end else begin
            ticks_next = quot[TICKS_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_data.op)
                        OP_START: state_next = ST_TDIV;
                        OP_TICK:  state_next = ST_EMIT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TDIV: begin
                state_next = ST_CDIV;
            end
            ST_CDIV: begin
                if (cdiv_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_fire && emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        ctrl.op      = CELL_IDLE;
        ctrl.channel = s_data.channel;
        ctrl.level   = s_data.level;
        ctrl.divisor = ticks_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_data.op)
                        OP_LOAD: ctrl.op = CELL_LOAD;
                        OP_TICK: ctrl.op = (ticks_reg != '0) ? CELL_TICK : CELL_CAPTURE;
                        default: ctrl.op = CELL_IDLE;
                    endcase
                end
            end
            ST_TDIV: begin
                ctrl.op = CELL_LATCH;
            end
            ST_CDIV: begin
                ctrl.op = CELL_DIV;
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready && !emit_last) begin
                    ctrl.op = CELL_SHIFT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ticks_reg    <= '0;
            step_reg     <= '0;
            emit_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    step_reg     <= '0;
                    emit_cnt_reg <= '0;
                    if (in_fire && s_data.op == OP_TICK && ticks_reg != '0) begin
                        ticks_reg <= ticks_reg - TICKS_W'(1);
                    end
                end
                ST_TDIV: begin
                    step_reg  <= '0;
                    ticks_reg <= ticks_next;
                end
                ST_CDIV: begin
                    step_reg <= step_reg + StepW'(1);
                end
                ST_EMIT: begin
                    if (out_fire) begin
                        emit_cnt_reg <= emit_cnt_reg + CntW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_fire) begin
            dvd_reg    <= s_data.duration_ms;
            fading_reg <= ticks_reg > TICKS_W'(1);
        end
    end

    assign chain[CHANNELS] = '0;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        dcf_cell #(
            .IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .shift_in  (chain[i+1]),
            .stage_out (chain[i])
        );
    end

    always_comb begin
        m_data.channel_out = CH_W'(emit_cnt_reg);
        m_data.level_out   = chain[0];
        m_data.fading      = fading_reg;
        m_data.last        = emit_last;
    end

endmodule

>>> src/dcf_cell.sv
`timescale 1ns / 1ps

module dcf_cell #(
    parameter int IDX = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dcf_pkg::cell_ctrl_t           ctrl,
    input  logic [dcf_pkg::LEVEL_W-1:0]   shift_in,
    output logic [dcf_pkg::LEVEL_W-1:0]   stage_out
);
    import dcf_pkg::*;

    localparam logic [CH_W:0] MyIdx = (CH_W+1)'(IDX);

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] target_reg;
    logic [LEVEL_W-1:0] quot_reg;
    logic               neg_reg;
    logic [LEVEL_W-1:0] mag_reg;
    logic [LEVEL_W-1:0] rem_reg, rem_next;
    logic [LEVEL_W-1:0] stage_reg;

    logic signed [LEVEL_W+1:0] sum;
    logic [LEVEL_W+1:0]        step_ext;
    logic [LEVEL_W:0]          diff;
    logic [LEVEL_W-1:0]        diff_mag;
    logic [LEVEL_W:0]          rem_sh;
    logic [TICKS_W-1:0]        rem_cmp;
    logic                      ge;

    // The step is kept as sign and magnitude; adding it clamps to the level range.
    always_comb begin
        step_ext = {2'b00, quot_reg};
        if (neg_reg) begin
            step_ext = -step_ext;
        end
        sum = $signed({2'b00, level_reg}) + $signed(step_ext);
        if (sum[LEVEL_W+1]) begin
            level_next = '0;
        end else if (sum[LEVEL_W]) begin
            level_next = '1;
        end else begin
            level_next = sum[LEVEL_W-1:0];
        end
    end

    always_comb begin
        diff     = {1'b0, target_reg} - {1'b0, level_reg};
        diff_mag = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
    end

    always_comb begin
        rem_sh  = {rem_reg, mag_reg[LEVEL_W-1]};
        rem_cmp = TICKS_W'(rem_sh);
        ge      = rem_cmp >= ctrl.divisor;
        if (ge) begin
            rem_next = LEVEL_W'(rem_cmp - ctrl.divisor);
        end else begin
            rem_next = rem_sh[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= '0;
            target_reg <= '0;
        end else begin
            case (ctrl.op)
                CELL_LOAD: begin
                    if ({1'b0, ctrl.channel} == MyIdx) begin
                        target_reg <= ctrl.level;
                    end
                end
                CELL_TICK: begin
                    level_reg <= level_next;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            CELL_TICK: begin
                stage_reg <= level_next;
            end
            CELL_CAPTURE: begin
                stage_reg <= level_reg;
            end
            CELL_SHIFT: begin
                stage_reg <= shift_in;
            end
            CELL_LATCH: begin
                neg_reg  <= diff[LEVEL_W];
                mag_reg  <= diff_mag;
                rem_reg  <= '0;
                quot_reg <= '0;
            end
            CELL_DIV: begin
                rem_reg  <= rem_next;
                mag_reg  <= {mag_reg[LEVEL_W-2:0], 1'b0};
                quot_reg <= {quot_reg[LEVEL_W-2:0], ge};
            end
            default: begin
            end
        endcase
    end

    assign stage_out = stage_reg;

endmodule
